// File: sv/jffp_pkg.sv
// Shared constants and types of the JEDEC fuse file parser.
`default_nettype none
package jffp_pkg;
  localparam int MAX_FUSES   = 131072;
  localparam int STORE_BYTES = (MAX_FUSES + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int NUM_CAP     = MAX_FUSES + 1;
  localparam int NUM_W       = $clog2(NUM_CAP + 1);

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_BEGIN = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_BAD_TSUM = 2'd2;
  localparam logic [1:0] ST_BAD_FSUM = 2'd3;

  localparam logic KIND_PARSE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    REQ_NONE, REQ_CLEAR, REQ_FILL, REQ_FUSE, REQ_READ
  } req_t;

  typedef struct packed {
    logic accept;
    logic sweep_wr;
    logic rmw_rd;
    logic rmw_wr;
    logic fin_rd;
    logic emit_parse;
    logic emit_read;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic fin;
    logic sweep_last;
  } dp_sts_t;
endpackage
`default_nettype wire

// File: sv/jedec_fuse_file_parser_top.sv
// Top level of the JEDEC fuse file parser.
// A file byte that sets a fuse does a store read-modify-write.
// A read item passes through the S_RD state; its result comes out on a registered strobe.
// Fill and begin walk the whole store, one byte per cycle, with busy high.
// The last byte adds a busy pass over the store for the final mask and sum, then the result.
// After reset a clearing pass over the whole store runs with busy high.
`default_nettype none
module jedec_fuse_file_parser_top import jffp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [13:0] in_read_address,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [17:0]      out_fuse_count,
  output logic [15:0]      out_fuse_sum,
  output logic [7:0]       out_read_data
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  jffp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  jffp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .in_read_address(in_read_address),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_status(out_status),
    .out_fuse_count(out_fuse_count), .out_fuse_sum(out_fuse_sum),
    .out_read_data(out_read_data)
  );
endmodule
`default_nettype wire

// File: sv/jffp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module jffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: sv/jffp_dp.sv
// Datapath: byte parser registers, fuse store and end-of-file sweep.
`default_nettype none
module jffp_dp import jffp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [13:0] in_read_address,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [17:0]      out_fuse_count,
  output logic [15:0]      out_fuse_sum,
  output logic [7:0]       out_read_data
);
  typedef enum logic [2:0] {
    PH_SEEK, PH_HEADER, PH_FIELDS, PH_TRAILER, PH_DONE
  } phase_t;
  typedef enum logic [2:0] {
    FK_GAP, FK_SKIP, FK_Q, FK_QF, FK_F, FK_LNUM, FK_LFUSE, FK_C
  } fkind_t;

  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [NUM_W+3:0] DEC_BASE = (NUM_W+4)'(10);

  phase_t ph_r, ph_nxt;
  fkind_t fk_r, fk_nxt;
  logic [15:0] ls_r, ls_nxt, tv_r, tv_nxt, es_r, es_nxt, ha_r, ha_nxt;
  logic [2:0]  td_r, td_nxt, hd_r, hd_nxt;
  logic [NUM_W-1:0] na_r, na_nxt, fi_r, fi_nxt, rc_r, rc_nxt, ec_r, ec_nxt;
  logic ns_r, ns_nxt, err_r, err_nxt;

  req_t req;
  logic [7:0] fill_v, fill_r;
  logic [ADDR_W-1:0] addr_r, addr_d_r, pend_addr_r;
  logic [2:0] pend_pos_r;
  logic pend_val_r, pv_r, oob_r;
  logic [15:0] sum_r;

  logic [7:0] c;
  logic digit, delim, hv;
  logic [3:0] h;
  logic [NUM_W+3:0] prod;
  logic [NUM_W-1:0] na_dig, cnt_v;
  logic cnt_err;

  always_comb begin
    c = in_data_byte;
    digit = c >= "0" && c <= "9";
    delim = c == " " || c == 8'd13 || c == 8'd10;
    hv = 1'b1;
    h = 4'd0;
    if (digit) h = c[3:0];
    else if (c >= "A" && c <= "F") h = 4'(c - "A" + 8'd10);
    else hv = 1'b0;
    prod = (NUM_W+4)'(na_r) * DEC_BASE + (NUM_W+4)'(c[3:0]);
    na_dig = (prod > (NUM_W+4)'(NUM_CAP)) ? NUM_W'(NUM_CAP) : NUM_W'(prod);
    cnt_err = na_r > NUM_W'(MAX_FUSES);
    cnt_v = cnt_err ? NUM_W'(MAX_FUSES) : na_r;
  end

  always_comb begin
    ph_nxt = ph_r; fk_nxt = fk_r; ls_nxt = ls_r; tv_nxt = tv_r; td_nxt = td_r;
    na_nxt = na_r; ns_nxt = ns_r; fi_nxt = fi_r; rc_nxt = rc_r; ec_nxt = ec_r;
    es_nxt = es_r; ha_nxt = ha_r; hd_nxt = hd_r; err_nxt = err_r;
    req = REQ_NONE;
    fill_v = 8'hff;
    sts.fin = 1'b0;
    if (cmd.accept) begin
      unique case (in_command)
        CMD_BYTE: begin
          if (ph_r != PH_DONE) begin
            sts.fin = in_last_byte;
            unique case (ph_r)
              PH_SEEK: begin
                if (c == CH_STX) begin
                  ph_nxt = PH_HEADER;
                  ls_nxt = 16'(CH_STX);
                end
              end
              PH_HEADER, PH_FIELDS: begin
                ls_nxt = ls_r + {9'd0, c[6:0]};
                if (c == CH_ETX) begin
                  if (ph_r == PH_FIELDS && fk_r != FK_GAP) err_nxt = 1'b1;
                  ph_nxt = PH_TRAILER;
                  tv_nxt = '0;
                  td_nxt = '0;
                end else if (ph_r == PH_HEADER) begin
                  if (c == CH_STAR) begin
                    ph_nxt = PH_FIELDS;
                    fk_nxt = FK_GAP;
                  end
                end else if (fk_r == FK_GAP) begin
                  if (!(delim || c == CH_STAR)) begin
                    na_nxt = '0; ns_nxt = 1'b0; ha_nxt = '0; hd_nxt = '0;
                    priority case (c)
                      "Q":     fk_nxt = FK_Q;
                      "F":     fk_nxt = FK_F;
                      "L":     fk_nxt = FK_LNUM;
                      "C":     fk_nxt = FK_C;
                      default: fk_nxt = FK_SKIP;
                    endcase
                  end
                end else if (c == CH_STAR) begin
                  if (fk_r == FK_QF) begin
                    err_nxt = err_r | cnt_err;
                    ec_nxt = cnt_v;
                    rc_nxt = cnt_v;
                  end else if (fk_r == FK_F) begin
                    req = REQ_FILL;
                  end else if (fk_r == FK_C && hd_r >= 3'd4) begin
                    es_nxt = ha_r;
                  end
                  fk_nxt = FK_GAP;
                end else begin
                  unique case (fk_r)
                    FK_Q: fk_nxt = (c == "F") ? FK_QF : FK_SKIP;
                    FK_QF, FK_LNUM: begin
                      if (!(!ns_r && delim)) begin
                        if (digit) begin
                          na_nxt = na_dig;
                          ns_nxt = 1'b1;
                        end else if (fk_r == FK_QF) begin
                          err_nxt = err_r | cnt_err;
                          ec_nxt = cnt_v;
                          rc_nxt = cnt_v;
                          fk_nxt = FK_SKIP;
                        end else begin
                          fi_nxt = na_r;
                          fk_nxt = FK_LFUSE;
                        end
                      end
                    end
                    FK_F: begin
                      req = REQ_FILL;
                      fill_v = (c == "0") ? 8'h00 : 8'hff;
                      fk_nxt = FK_SKIP;
                    end
                    FK_LFUSE: begin
                      if (c == "0" || c == "1") begin
                        if (fi_r >= NUM_W'(MAX_FUSES)) begin
                          err_nxt = 1'b1;
                        end else begin
                          req = REQ_FUSE;
                          if (fi_r >= rc_r) rc_nxt = fi_r + 1'b1;
                          fi_nxt = fi_r + 1'b1;
                        end
                      end
                    end
                    FK_C: begin
                      if (hv) begin
                        ha_nxt = {ha_r[11:0], h};
                        if (hd_r < 3'd4) hd_nxt = hd_r + 3'd1;
                      end else begin
                        if (hd_r >= 3'd4) es_nxt = ha_r;
                        fk_nxt = FK_SKIP;
                      end
                    end
                    default: ;
                  endcase
                end
              end
              PH_TRAILER: begin
                if (td_r < 3'd4) begin
                  if (hv) begin
                    tv_nxt = {tv_r[11:0], h};
                    td_nxt = td_r + 3'd1;
                  end else begin
                    td_nxt = 3'd5;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        CMD_READ: req = REQ_READ;
        CMD_BEGIN: begin
          req = REQ_CLEAR;
          ph_nxt = PH_SEEK; fk_nxt = FK_GAP; ls_nxt = '0; tv_nxt = '0; td_nxt = '0;
          na_nxt = '0; ns_nxt = 1'b0; fi_nxt = '0; rc_nxt = '0; ec_nxt = '0;
          es_nxt = '0; ha_nxt = '0; hd_nxt = '0; err_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.emit_parse) ph_nxt = PH_DONE;
    sts.req = req;
    sts.sweep_last = addr_r == ADDR_W'(STORE_BYTES - 1);
  end

  // end-of-file figures
  logic [NUM_W-1:0] n, used, mbyte;
  logic [7:0] mask, rdata, fin_d;
  logic in_use;
  logic [1:0] st;

  always_comb begin
    n = (ec_r != '0) ? ec_r : rc_r;
    used = (n + NUM_W'(7)) >> 3;
    mbyte = n >> 3;
    mask = 8'((9'd1 << n[2:0]) - 9'd1);
    in_use = NUM_W'(addr_d_r) < used;
    fin_d = 8'd0;
    if (in_use) begin
      fin_d = (NUM_W'(addr_d_r) == mbyte && n[2:0] != 3'd0) ? (rdata & mask) : rdata;
    end
    if (ph_r != PH_TRAILER) st = ST_INVALID;
    else if (td_r == 3'd4 && tv_r != '0 && tv_r != ls_r) st = ST_BAD_TSUM;
    else if (err_r) st = ST_INVALID;
    else if (es_r != '0 && sum_r != es_r) st = ST_BAD_FSUM;
    else st = ST_OK;
  end

  logic we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0] wdata;

  always_comb begin
    we = 1'b0; waddr = addr_r; wdata = fill_r;
    if (cmd.sweep_wr) begin
      we = 1'b1;
    end else if (cmd.rmw_wr) begin
      we = 1'b1;
      waddr = pend_addr_r;
      wdata = (rdata & ~(8'd1 << pend_pos_r)) | (8'(pend_val_r) << pend_pos_r);
    end else if (pv_r) begin
      we = 1'b1;
      waddr = addr_d_r;
      wdata = fin_d;
    end
    re = cmd.rmw_rd || cmd.fin_rd || (cmd.accept && in_command == CMD_READ);
    raddr = cmd.rmw_rd ? pend_addr_r : (cmd.fin_rd ? addr_r : ADDR_W'(in_read_address));
  end

  jffp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_SEEK; fk_r <= FK_GAP; ls_r <= '0; tv_r <= '0; td_r <= '0;
      na_r <= '0; ns_r <= 1'b0; fi_r <= '0; rc_r <= '0; ec_r <= '0;
      es_r <= '0; ha_r <= '0; hd_r <= '0; err_r <= 1'b0;
      addr_r <= '0; fill_r <= 8'd0; pv_r <= 1'b0; out_strobe <= 1'b0;
    end else begin
      ph_r <= ph_nxt; fk_r <= fk_nxt; ls_r <= ls_nxt; tv_r <= tv_nxt; td_r <= td_nxt;
      na_r <= na_nxt; ns_r <= ns_nxt; fi_r <= fi_nxt; rc_r <= rc_nxt; ec_r <= ec_nxt;
      es_r <= es_nxt; ha_r <= ha_nxt; hd_r <= hd_nxt; err_r <= err_nxt;
      pv_r <= cmd.fin_rd;
      out_strobe <= cmd.emit_parse || cmd.emit_read;
      if (cmd.accept) begin
        addr_r <= '0;
        if (req == REQ_CLEAR) fill_r <= 8'd0;
        else if (req == REQ_FILL) fill_r <= fill_v;
      end else if (cmd.sweep_wr || cmd.fin_rd) begin
        addr_r <= sts.sweep_last ? '0 : addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_d_r <= addr_r;
    if (cmd.accept) begin
      sum_r <= '0;
      pend_addr_r <= ADDR_W'(fi_r >> 3);
      pend_pos_r <= fi_r[2:0];
      pend_val_r <= c[0];
      oob_r <= int'(in_read_address) >= STORE_BYTES;
    end else if (pv_r) begin
      sum_r <= sum_r + 16'(fin_d);
    end
    if (cmd.emit_parse) begin
      out_kind <= KIND_PARSE;
      out_status <= st;
      out_fuse_count <= 18'(n);
      out_fuse_sum <= sum_r;
      out_read_data <= 8'd0;
    end else if (cmd.emit_read) begin
      out_kind <= KIND_READ;
      out_status <= ST_OK;
      out_fuse_count <= '0;
      out_fuse_sum <= '0;
      out_read_data <= oob_r ? 8'd0 : rdata;
    end
  end
endmodule
`default_nettype wire

// File: sv/jffp_ctrl.sv
// Controller: handshake and sequencing of store sweeps and updates.
`default_nettype none
module jffp_ctrl import jffp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_RMW_RD, S_RMW_WR, S_RD, S_FIN, S_FIN_TAIL, S_EMIT
  } state_t;

  state_t state_r;
  logic fin_r;

  always_comb begin
    busy = state_r != S_IDLE;
    cmd.accept = start && state_r == S_IDLE;
    cmd.sweep_wr = state_r == S_SWEEP;
    cmd.rmw_rd = state_r == S_RMW_RD;
    cmd.rmw_wr = state_r == S_RMW_WR;
    cmd.fin_rd = state_r == S_FIN;
    cmd.emit_parse = state_r == S_EMIT;
    cmd.emit_read = state_r == S_RD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      fin_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept) begin
            fin_r <= sts.fin;
            unique case (sts.req)
              REQ_CLEAR, REQ_FILL: state_r <= S_SWEEP;
              REQ_FUSE:            state_r <= S_RMW_RD;
              REQ_READ:            state_r <= S_RD;
              default:             state_r <= sts.fin ? S_FIN : S_IDLE;
            endcase
          end
        end
        S_SWEEP: begin
          if (sts.sweep_last) state_r <= fin_r ? S_FIN : S_IDLE;
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: state_r <= fin_r ? S_FIN : S_IDLE;
        S_RD:     state_r <= S_IDLE;
        S_FIN: begin
          if (sts.sweep_last) state_r <= S_FIN_TAIL;
        end
        S_FIN_TAIL: state_r <= S_EMIT;
        S_EMIT: begin
          state_r <= S_IDLE;
          fin_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/jffp_checker.sv
// Port-level assertions for the parser top level, with bind.
`default_nettype none
module jffp_port_checks import jffp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_command,
  input wire logic        out_strobe,
  input wire logic        out_kind,
  input wire logic [1:0]  out_status,
  input wire logic [17:0] out_fuse_count,
  input wire logic [15:0] out_fuse_sum,
  input wire logic [7:0]  out_read_data
);
  a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_READ |=> busy ##1 (out_strobe && out_kind == KIND_READ))
    else $error("read item result timing");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_READ |->
      out_status == ST_OK && out_fuse_count == '0 && out_fuse_sum == '0)
    else $error("read result carries parse fields");

  a_parse_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_PARSE |-> out_read_data == 8'd0)
    else $error("parse result carries read data");

  a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_BEGIN |=> busy)
    else $error("begin did not start clearing");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("no clearing pass after reset");
endmodule

bind jedec_fuse_file_parser_top jffp_port_checks u_jffp_port_checks (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_command(in_command),
  .out_strobe(out_strobe), .out_kind(out_kind), .out_status(out_status),
  .out_fuse_count(out_fuse_count), .out_fuse_sum(out_fuse_sum),
  .out_read_data(out_read_data)
);
`default_nettype wire
